/* hw/rtl/gcht_pkg.sv */
// Shared types and constants for the generation checked handle table.
// Used by gcht_ctrl, gcht_dp and generation_checked_handle_table_top.
package gcht_pkg;

   localparam int SLOTS       = 32;
   localparam int MAX_PLANES  = 6;
   localparam int ADDR_BITS   = 24;
   localparam int MAX_RESULTS = 32;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

   localparam logic [11:0] MAX_DIM = 12'd2048;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_SWEEP = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SIZE   = 3'd1,
      ST_FULL       = 3'd2,
      ST_BAD_HANDLE = 3'd3,
      ST_NO_SLOTS   = 3'd4
   } status_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] handle;
      logic [7:0]  owner_id;
      logic [23:0] base_address;
      logic [11:0] width;
      logic [11:0] height;
      logic [3:0]  plane_count;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] result_handle;
      logic [23:0] info_base;
      logic [11:0] info_width;
      logic [11:0] info_height;
      logic [2:0]  info_planes;
      logic [8:0]  row_stride;
      logic [19:0] plane_bytes;
      logic [7:0]  slot_owner;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] base;
      logic [11:0]          width;
      logic [11:0]          height;
      logic [2:0]           planes;
   } slot_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;
      logic       alloc;
      logic       open_handle;
      logic       release_slot;
      logic       load_mask;
      logic       pick;
      logic       set_result;
      status_type code;
      logic       fail;
      logic       last;
      logic       load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      mode_type mode;
      logic     size_ok;
      logic     has_free;
      logic     handle_ok;
      logic     mask_any;
      logic     out_free;
      logic     last_pending;
   } sts_type;

endpackage

/* hw/rtl/generation_checked_handle_table_top.sv */
// Generation checked handle table: allocate, free, query and owner sweep.
// A request is captured, decoded, then loaded into the output register once that has room.
// A new request is accepted only in idle, after the last result word of the previous one
// is loaded; an owner sweep walks the controller's sweep/emit states once per freed slot.
// Reset (synchronous, active high) clears all used bits and generations.
// Depends on gcht_pkg, gcht_ctrl and gcht_dp.
module generation_checked_handle_table_top (
   input  logic          clock,
   input  logic          reset,
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   // handle[15:0], owner_id[23:16], base_address[47:24], width[59:48],
   // height[71:60], plane_count[75:72], zero pad [79:76]
   input  logic [79:0]   req_tdata,
   // mode[1:0]
   input  logic [1:0]    req_tuser,
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[2:0], result_handle[18:3], info_base[42:19], info_width[54:43],
   // info_height[66:55], info_planes[69:67], row_stride[78:70],
   // plane_bytes[98:79], slot_owner[106:99], zero pad [111:107]
   output logic [111:0]  rsp_tdata,
   output logic          rsp_tlast
);
   import gcht_pkg::*;

   req_type req;
   rsp_type rsp;
   cmd_type cmd;
   sts_type sts;

   // unpack the request word
   always_comb begin
      req.mode         = mode_type'(req_tuser);
      req.handle       = req_tdata[15:0];
      req.owner_id     = req_tdata[23:16];
      req.base_address = req_tdata[47:24];
      req.width        = req_tdata[59:48];
      req.height       = req_tdata[71:60];
      req.plane_count  = req_tdata[75:72];
   end

   // sequence each request: accept, decode, then one emit per result word (a sweep picks a slot before each)
   gcht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // slot state, searches and the output register
   gcht_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req        (req),
      .rsp        (rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // pack the result word, last mark travels on tlast
   assign rsp_tdata = {5'd0, rsp.slot_owner, rsp.plane_bytes, rsp.row_stride,
                       rsp.info_planes, rsp.info_height, rsp.info_width,
                       rsp.info_base, rsp.result_handle, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

/* hw/rtl/gcht_dp.sv */
// Datapath of the handle table: slot stores, generation and used bits,
// first-free and sweep search, result build and output register. Uses gcht_pkg.
module gcht_dp (
   input  logic              clock,
   input  logic              reset,
   input  gcht_pkg::cmd_type cmd,
   output gcht_pkg::sts_type sts,
   input  gcht_pkg::req_type req,
   output gcht_pkg::rsp_type rsp,
   output logic              rsp_tvalid,
   input  logic              rsp_tready
);
   import gcht_pkg::*;

   req_type              req_ff;
   logic [SLOTS-1:0]     used_ff;
   logic [7:0]           gen_ff [SLOTS];
   logic [7:0]           owner_ff [SLOTS];
   slot_type             slot_mem [SLOTS];
   slot_type             rd_ff;
   logic [SLOTS-1:0]     mask_ff;
   logic [SLOTS-1:0]     mask_in;
   logic [CNT_W-1:0]     count_ff;
   logic [SLOT_W-1:0]    sel_ff;
   status_type           status_ff;
   logic                 fail_ff;
   logic                 last_ff;
   logic                 from_req_ff;
   rsp_type              out_ff;
   rsp_type              out_in;
   logic                 out_valid_ff;

   logic                 size_ok;
   logic                 has_free;
   logic [SLOT_W-1:0]    free_idx;
   logic                 mask_any;
   logic [SLOT_W-1:0]    pick_idx;
   logic                 pick_last;
   logic [7:0]           h_low;
   logic                 h_in_range;
   logic [SLOT_W-1:0]    h_slot;
   logic                 handle_ok;
   logic                 out_free;
   logic [SLOT_W-1:0]    rd_addr;
   logic [ADDR_BITS-1:0] req_base;
   slot_type             entry;
   logic [8:0]           bpr;
   logic [20:0]          area;

   // request checks
   always_comb begin
      size_ok = (req_ff.width != 12'd0) && (req_ff.width <= MAX_DIM) &&
                (req_ff.width[3:0] == 4'd0) &&
                (req_ff.height != 12'd0) && (req_ff.height <= MAX_DIM) &&
                (req_ff.plane_count != 4'd0) &&
                (req_ff.plane_count <= 4'(MAX_PLANES));
   end

   assign h_low      = req_ff.handle[7:0];
   assign h_in_range = (h_low != 8'd0) && (9'(h_low) <= 9'(SLOTS));
   assign h_slot     = SLOT_W'(h_low - 8'd1);
   assign handle_ok  = h_in_range && used_ff[h_slot] &&
                       (gen_ff[h_slot] == req_ff.handle[15:8]);

   // lowest free slot
   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            has_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // owner match mask and lowest pending match
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         mask_in[i] = used_ff[i] && (owner_ff[i] == req_ff.owner_id);
      end
   end

   always_comb begin
      mask_any = 1'b0;
      pick_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            mask_any = 1'b1;
            pick_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      logic [SLOTS-1:0] rest;
      rest = mask_ff;
      rest[pick_idx] = 1'b0;
      pick_last = (rest == '0) || (count_ff == CNT_W'(MAX_RESULTS - 1));
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      sts              = '0;
      sts.mode         = req_ff.mode;
      sts.size_ok      = size_ok;
      sts.has_free     = has_free;
      sts.handle_ok    = handle_ok;
      sts.mask_any     = mask_any;
      sts.out_free     = out_free;
      sts.last_pending = last_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         mask_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            gen_ff[i] <= 8'd0;
         end
      end else begin
         if (cmd.alloc) begin
            used_ff[free_idx] <= 1'b1;
            gen_ff[free_idx]  <= gen_ff[free_idx] + 8'd1;
         end
         if (cmd.release_slot) begin
            used_ff[h_slot] <= 1'b0;
         end
         if (cmd.load_mask) begin
            mask_ff  <= mask_in;
            count_ff <= '0;
         end
         if (cmd.pick) begin
            used_ff[pick_idx] <= 1'b0;
            mask_ff[pick_idx] <= 1'b0;
            count_ff          <= count_ff + CNT_W'(1);
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign req_base = ADDR_BITS'(req_ff.base_address);
   assign rd_addr  = cmd.pick ? pick_idx : h_slot;

   // slot store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         slot_mem[free_idx] <= '{base:   req_base,
                                 width:  req_ff.width,
                                 height: req_ff.height,
                                 planes: 3'(req_ff.plane_count)};
         owner_ff[free_idx] <= req_ff.owner_id;
      end
      if (cmd.open_handle || cmd.pick) begin
         rd_ff <= slot_mem[rd_addr];
      end
   end

   // request and result bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (cmd.alloc) begin
         sel_ff <= free_idx;
      end else if (cmd.open_handle) begin
         sel_ff <= h_slot;
      end else if (cmd.pick) begin
         sel_ff <= pick_idx;
      end
      if (cmd.set_result) begin
         status_ff   <= cmd.code;
         fail_ff     <= cmd.fail;
         last_ff     <= cmd.pick ? pick_last : cmd.last;
         from_req_ff <= cmd.alloc;
      end
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

   // result build: a fresh allocation reports the request, the rest the store
   always_comb begin
      if (from_req_ff) begin
         entry = '{base:   req_base,
                   width:  req_ff.width,
                   height: req_ff.height,
                   planes: 3'(req_ff.plane_count)};
      end else begin
         entry = rd_ff;
      end
      bpr  = 9'(entry.width >> 3);
      area = bpr * entry.height;
      out_in        = '0;
      out_in.status = status_ff;
      out_in.last   = last_ff;
      if (!fail_ff) begin
         out_in.result_handle = {gen_ff[sel_ff], 8'(sel_ff) + 8'd1};
         out_in.info_base     = 24'(entry.base);
         out_in.info_width    = entry.width;
         out_in.info_height   = entry.height;
         out_in.info_planes   = entry.planes;
         out_in.row_stride    = bpr;
         out_in.plane_bytes   = 20'(area);
         out_in.slot_owner    = owner_ff[sel_ff];
      end
   end

   assign rsp        = out_ff;
   assign rsp_tvalid = out_valid_ff;

`ifndef SYNTH
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("output register overwritten while full");
   a_alloc_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> (size_ok && has_free))
      else $error("allocation without a free slot or with a bad size");
   a_alloc_marks_used: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |=> used_ff[$past(free_idx)])
      else $error("allocated slot not marked used");
   a_pick_has_match: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> mask_any)
      else $error("sweep picked a slot with no pending match");
`endif

endmodule

/* hw/rtl/gcht_ctrl.sv */
// Controller state machine of the handle table: sequences accept, decode,
// sweep and result output. Drives gcht_dp through cmd_type; uses gcht_pkg.
module gcht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  gcht_pkg::sts_type sts,
   output gcht_pkg::cmd_type cmd
);
   import gcht_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECODE = 4'b0010,
      S_SWEEP  = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.code = ST_OK;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.mode) inside
               MODE_ALLOC: begin
                  cmd.set_result = 1'b1;
                  cmd.last       = 1'b1;
                  if (!sts.size_ok) begin
                     cmd.code = ST_BAD_SIZE;
                     cmd.fail = 1'b1;
                  end else if (!sts.has_free) begin
                     cmd.code = ST_FULL;
                     cmd.fail = 1'b1;
                  end else begin
                     cmd.alloc = 1'b1;
                  end
                  state_in = S_EMIT;
               end
               MODE_FREE, MODE_QUERY: begin
                  cmd.set_result = 1'b1;
                  cmd.last       = 1'b1;
                  if (!sts.handle_ok) begin
                     cmd.code = ST_BAD_HANDLE;
                     cmd.fail = 1'b1;
                  end else begin
                     cmd.open_handle  = 1'b1;
                     cmd.release_slot = (sts.mode == MODE_FREE);
                  end
                  state_in = S_EMIT;
               end
               MODE_SWEEP: begin
                  cmd.load_mask = 1'b1;
                  state_in      = S_SWEEP;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SWEEP: begin
            // every pick that ends the sweep carries last, so an empty mask
            // here means the owner held nothing
            cmd.set_result = 1'b1;
            if (sts.mask_any) begin
               cmd.pick = 1'b1;
            end else begin
               cmd.code = ST_NO_SLOTS;
               cmd.fail = 1'b1;
               cmd.last = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = sts.last_pending ? S_IDLE : S_SWEEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for generation_checked_handle_table_top.
// Holds a slot-table predictor, directed and random request streams and a result checker.
// Depends on gcht_pkg and the RTL of the handle table.
module testbench;
   import gcht_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [23:0] ADDR_KEEP = 24'((64'd1 << ADDR_BITS) - 1);

   // one row of the directed table; known rows carry status and handle typed in
   typedef struct packed {
      mode_type    mode;
      logic [15:0] handle;
      logic [7:0]  owner;
      logic [23:0] base;
      logic [11:0] width;
      logic [11:0] height;
      logic [3:0]  planes;
      logic        known;
      status_type  known_status;
      logic [15:0] known_handle;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   // handle[15:0], owner_id[23:16], base_address[47:24], width[59:48],
   // height[71:60], plane_count[75:72], zero pad [79:76]
   logic [79:0]   req_tdata = '0;
   // mode[1:0]
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // status[2:0], result_handle[18:3], info_base[42:19], info_width[54:43],
   // info_height[66:55], info_planes[69:67], row_stride[78:70],
   // plane_bytes[98:79], slot_owner[106:99], zero pad [111:107]
   logic [111:0]  rsp_tdata;
   logic          rsp_tlast;

   generation_checked_handle_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Predicted slot table, a private copy of what the block should hold.
   logic        slot_held [SLOTS];
   logic [7:0]  slot_gen  [SLOTS];
   logic [7:0]  slot_own  [SLOTS];
   logic [23:0] slot_addr [SLOTS];
   logic [11:0] slot_wd   [SLOTS];
   logic [11:0] slot_ht   [SLOTS];
   logic [3:0]  slot_pl   [SLOTS];

   rsp_type     pending_results [$];
   logic [15:0] last_alloc_handle;

   int          cycle_count = 0;
   int          error_count = 0;
   int          requests_sent = 0;
   int          results_seen = 0;
   int          slots_swept = 0;
   int          hold_left = 0;
   bit          hold_done = 0;
   rsp_type     rsp_want;
   rsp_type     rsp_got;
   stim_row_type directed_rows [0:24];

   // no idling on either side inside this window
   logic calm;
   assign calm = (cycle_count >= 700) && (cycle_count < 1100);

   function automatic rsp_type failure_word(status_type st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rsp_type slot_word(int s, logic lst);
      rsp_type     r;
      logic [31:0] row_bytes;
      row_bytes = 32'(slot_wd[s]) / 8;
      r.status = ST_OK;
      r.result_handle = {slot_gen[s], 8'(s + 1)};
      r.info_base = slot_addr[s];
      r.info_width = slot_wd[s];
      r.info_height = slot_ht[s];
      r.info_planes = slot_pl[s][2:0];
      r.row_stride = row_bytes[8:0];
      r.plane_bytes = 20'(row_bytes * 32'(slot_ht[s]));
      r.slot_owner = slot_own[s];
      r.last = lst;
      return r;
   endfunction

   // Return the slot a handle names, or -1 when it is stale, unused or malformed.
   function automatic int locate_slot(logic [15:0] hnd);
      int s;
      s = int'(hnd[7:0]) - 1;
      if (hnd[7:0] == 8'd0 || s >= SLOTS) return -1;
      if (!slot_held[s] || slot_gen[s] != hnd[15:8]) return -1;
      return s;
   endfunction

   // Advance the predicted table by one request and queue the words it causes.
   task automatic apply_request(input mode_type m, input logic [15:0] hnd,
                                input logic [7:0] own, input logic [23:0] addr,
                                input logic [11:0] w, input logic [11:0] h,
                                input logic [3:0] p);
      int      s;
      int      freed;
      rsp_type held_back;
      bit      have_back;
      s = 0;
      freed = 0;
      have_back = 0;
      case (m)
         MODE_ALLOC: begin
            if (w == 0 || w > MAX_DIM || w[3:0] != 4'd0 || h == 0 || h > MAX_DIM ||
                p == 0 || p > MAX_PLANES) begin
               pending_results.push_back(failure_word(ST_BAD_SIZE));
            end else begin
               while (s < SLOTS && slot_held[s]) s++;
               if (s >= SLOTS) begin
                  pending_results.push_back(failure_word(ST_FULL));
               end else begin
                  slot_held[s] = 1'b1;
                  slot_gen[s] = slot_gen[s] + 8'd1;
                  slot_own[s] = own;
                  slot_addr[s] = addr & ADDR_KEEP;
                  slot_wd[s] = w;
                  slot_ht[s] = h;
                  slot_pl[s] = p;
                  last_alloc_handle = {slot_gen[s], 8'(s + 1)};
                  pending_results.push_back(slot_word(s, 1'b1));
               end
            end
         end
         MODE_FREE, MODE_QUERY: begin
            s = locate_slot(hnd);
            if (s < 0) begin
               pending_results.push_back(failure_word(ST_BAD_HANDLE));
            end else begin
               pending_results.push_back(slot_word(s, 1'b1));
               if (m == MODE_FREE) slot_held[s] = 1'b0;
            end
         end
         default: begin
            // sweep: free the owner's slots in ascending order, mark the last word
            for (s = 0; s < SLOTS && freed < MAX_RESULTS; s++) begin
               if (slot_held[s] && slot_own[s] == own) begin
                  if (have_back) pending_results.push_back(held_back);
                  held_back = slot_word(s, 1'b0);
                  have_back = 1;
                  slot_held[s] = 1'b0;
                  freed++;
               end
            end
            if (!have_back) begin
               pending_results.push_back(failure_word(ST_NO_SLOTS));
            end else begin
               held_back.last = 1'b1;
               pending_results.push_back(held_back);
            end
            slots_swept += freed;
         end
      endcase
   endtask

   // Offer one request word, idle at random beforehand, predict once accepted.
   // Returns in the step of acceptance without touching req_tvalid there.
   task automatic send_item(input mode_type m, input logic [15:0] hnd,
                            input logic [7:0] own, input logic [23:0] addr,
                            input logic [11:0] w, input logic [11:0] h,
                            input logic [3:0] p);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= m;
      req_tdata <= {4'd0, p, h, w, addr, own, hnd};
      do @(posedge clock); while (!req_tready);
      apply_request(m, hnd, own, addr, w, h, p);
      requests_sent++;
   endtask

   // Random allocate; the size is well formed when well_formed is set, else random.
   task automatic send_alloc(input logic [7:0] own, input bit well_formed);
      if (well_formed) begin
         send_item(MODE_ALLOC, 16'($urandom), own, 24'($urandom),
                   12'(16 * $urandom_range(1, 128)), 12'($urandom_range(1, 2048)),
                   4'($urandom_range(1, MAX_PLANES)));
      end else begin
         send_item(MODE_ALLOC, 16'($urandom), own, 24'($urandom),
                   12'($urandom), 12'($urandom), 4'($urandom));
      end
   endtask

   // Pick a handle: mostly a live one, else a stale copy of one, else noise.
   function automatic logic [15:0] pick_handle();
      int start;
      int pick;
      int k;
      int s;
      start = $urandom_range(0, SLOTS - 1);
      pick = $urandom_range(99);
      if (pick < 85) begin
         for (k = 0; k < SLOTS; k++) begin
            s = (start + k) % SLOTS;
            if (slot_held[s]) begin
               if (pick < 70) return {slot_gen[s], 8'(s + 1)};
               return {slot_gen[s] ^ 8'($urandom_range(1, 255)), 8'(s + 1)};
            end
         end
      end
      return 16'($urandom);
   endfunction

   // Result checker and receiver-side flow control.
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result words outstanding", $time,
                  pending_results.size());
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         rsp_got.status = status_type'(rsp_tdata[2:0]);
         rsp_got.result_handle = rsp_tdata[18:3];
         rsp_got.info_base = rsp_tdata[42:19];
         rsp_got.info_width = rsp_tdata[54:43];
         rsp_got.info_height = rsp_tdata[66:55];
         rsp_got.info_planes = rsp_tdata[69:67];
         rsp_got.row_stride = rsp_tdata[78:70];
         rsp_got.plane_bytes = rsp_tdata[98:79];
         rsp_got.slot_owner = rsp_tdata[106:99];
         rsp_got.last = rsp_tlast;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %0h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            rsp_want = pending_results.pop_front();
            check_field("status", 32'(rsp_want.status), 32'(rsp_got.status));
            check_field("result_handle", 32'(rsp_want.result_handle),
                        32'(rsp_got.result_handle));
            check_field("info_base", 32'(rsp_want.info_base), 32'(rsp_got.info_base));
            check_field("info_width", 32'(rsp_want.info_width), 32'(rsp_got.info_width));
            check_field("info_height", 32'(rsp_want.info_height),
                        32'(rsp_got.info_height));
            check_field("info_planes", 32'(rsp_want.info_planes),
                        32'(rsp_got.info_planes));
            check_field("row_stride", 32'(rsp_want.row_stride),
                        32'(rsp_got.row_stride));
            check_field("plane_bytes", 32'(rsp_want.plane_bytes),
                        32'(rsp_got.plane_bytes));
            check_field("slot_owner", 32'(rsp_want.slot_owner), 32'(rsp_got.slot_owner));
            check_field("last", 32'(rsp_want.last), 32'(rsp_got.last));
         end
      end
      // Hold off once for a long stretch so that the block backs up into its input;
      // otherwise stall at random outside the calm window.
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 30) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 15);
      end
   end

   // Stimulus.
   initial begin
      int          i;
      int          pick;
      logic [7:0]  own;
      logic [15:0] hnd;
      logic [15:0] stale_handle;
      rsp_type     typed;

      for (i = 0; i < SLOTS; i++) begin
         slot_held[i] = 1'b0;
         slot_gen[i] = 8'd0;
         slot_own[i] = 8'd0;
         slot_addr[i] = 24'd0;
         slot_wd[i] = 12'd0;
         slot_ht[i] = 12'd0;
         slot_pl[i] = 4'd0;
      end
      last_alloc_handle = 16'd0;

      // mode, handle, owner, base, width, height, planes, known, status, handle
      directed_rows = '{
         // empty table: nothing to find, nothing to sweep
         '{MODE_QUERY, 16'h0000, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_BAD_HANDLE, 16'h0000},
         '{MODE_FREE, 16'h0101, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_BAD_HANDLE, 16'h0000},
         '{MODE_SWEEP, 16'h0000, 8'h05, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_NO_SLOTS, 16'h0000},
         // every way a size can be refused
         '{MODE_ALLOC, 16'h0000, 8'h01, 24'h000100, 12'd0, 12'd16, 4'd1,
           1'b1, ST_BAD_SIZE, 16'h0000},
         '{MODE_ALLOC, 16'h0000, 8'h01, 24'h000100, 12'd2064, 12'd16, 4'd1,
           1'b1, ST_BAD_SIZE, 16'h0000},
         '{MODE_ALLOC, 16'h0000, 8'h01, 24'h000100, 12'd24, 12'd16, 4'd1,
           1'b1, ST_BAD_SIZE, 16'h0000},
         '{MODE_ALLOC, 16'h0000, 8'h01, 24'h000100, 12'd16, 12'd0, 4'd1,
           1'b1, ST_BAD_SIZE, 16'h0000},
         '{MODE_ALLOC, 16'h0000, 8'h01, 24'h000100, 12'd16, 12'd2049, 4'd1,
           1'b1, ST_BAD_SIZE, 16'h0000},
         '{MODE_ALLOC, 16'h0000, 8'h01, 24'h000100, 12'd16, 12'd16, 4'd0,
           1'b1, ST_BAD_SIZE, 16'h0000},
         '{MODE_ALLOC, 16'h0000, 8'h01, 24'h000100, 12'd16, 12'd16, 4'd7,
           1'b1, ST_BAD_SIZE, 16'h0000},
         '{MODE_ALLOC, 16'hFFFF, 8'hFF, 24'hFFFFFF, 12'd4095, 12'd4095, 4'd15,
           1'b1, ST_BAD_SIZE, 16'h0000},
         // largest and smallest legal bitmaps land in slots 0 and 1
         '{MODE_ALLOC, 16'hFFFF, 8'hFF, 24'hFFFFFF, 12'd2048, 12'd2048, 4'd6,
           1'b1, ST_OK, 16'h0101},
         '{MODE_ALLOC, 16'h0000, 8'h00, 24'h000000, 12'd16, 12'd1, 4'd1,
           1'b1, ST_OK, 16'h0102},
         '{MODE_QUERY, 16'h0101, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_OK, 16'h0101},
         // stale generation, slot past the end, slot byte zero
         '{MODE_QUERY, 16'h0201, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_BAD_HANDLE, 16'h0000},
         '{MODE_QUERY, 16'h0121, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_BAD_HANDLE, 16'h0000},
         '{MODE_QUERY, 16'h01FF, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_BAD_HANDLE, 16'h0000},
         '{MODE_QUERY, 16'h0100, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_BAD_HANDLE, 16'h0000},
         // free, double free, then reuse of slot 0 with the next generation
         '{MODE_FREE, 16'h0101, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_OK, 16'h0101},
         '{MODE_FREE, 16'h0101, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_BAD_HANDLE, 16'h0000},
         '{MODE_ALLOC, 16'h0000, 8'hFF, 24'h123456, 12'd2048, 12'd2048, 4'd6,
           1'b1, ST_OK, 16'h0201},
         '{MODE_QUERY, 16'h0102, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b0, ST_OK, 16'h0000},
         // sweeps of the two owners, then an owner that is now empty
         '{MODE_SWEEP, 16'h0000, 8'hFF, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b0, ST_OK, 16'h0000},
         '{MODE_SWEEP, 16'h0000, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b0, ST_OK, 16'h0000},
         '{MODE_SWEEP, 16'h0000, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0,
           1'b1, ST_NO_SLOTS, 16'h0000}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; typed rows override the predicted status and handle.
      for (i = 0; i < 25; i++) begin
         send_item(directed_rows[i].mode, directed_rows[i].handle, directed_rows[i].owner,
                   directed_rows[i].base, directed_rows[i].width, directed_rows[i].height,
                   directed_rows[i].planes);
         if (directed_rows[i].known) begin
            typed = pending_results.pop_back();
            typed.status = directed_rows[i].known_status;
            typed.result_handle = directed_rows[i].known_handle;
            pending_results.push_back(typed);
         end
      end

      // Fill every slot for one owner, overflow once, then sweep the full table.
      // The long receiver hold-off falls in here.
      for (i = 0; i <= SLOTS; i++) send_alloc(8'h3C, 1'b1);
      send_item(MODE_SWEEP, 16'($urandom), 8'h3C, 24'($urandom), 12'($urandom),
                12'($urandom), 4'($urandom));

      // Mixed traffic over a small pool of owners.
      for (i = 0; i < 160; i++) begin
         pick = $urandom_range(99);
         own = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 3)) : 8'($urandom);
         if (pick < 40) begin
            send_alloc(own, $urandom_range(99) < 85);
         end else if (pick < 60) begin
            send_item(MODE_FREE, pick_handle(), own, 24'($urandom), 12'($urandom),
                      12'($urandom), 4'($urandom));
         end else if (pick < 78) begin
            send_item(MODE_QUERY, pick_handle(), own, 24'($urandom), 12'($urandom),
                      12'($urandom), 4'($urandom));
         end else if (pick < 88) begin
            send_item(MODE_SWEEP, 16'($urandom), own, 24'($urandom), 12'($urandom),
                      12'($urandom), 4'($urandom));
         end else begin
            send_item(mode_type'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                      24'($urandom), 12'($urandom), 12'($urandom), 4'($urandom));
         end
      end

      // Empty the table by sweeping whatever owner still holds a slot.
      for (i = 0; i < SLOTS; i++) begin
         while (slot_held[i]) begin
            send_item(MODE_SWEEP, 16'($urandom), slot_own[i], 24'($urandom),
                      12'($urandom), 12'($urandom), 4'($urandom));
         end
      end

      // Cycle slot 0 through a run of generations, then query its first handle.
      stale_handle = 16'd0;
      for (i = 0; i < 16; i++) begin
         send_alloc(8'($urandom), 1'b1);
         hnd = last_alloc_handle;
         if (i == 0) stale_handle = hnd;
         send_item(MODE_FREE, hnd, 8'($urandom), 24'($urandom), 12'($urandom),
                   12'($urandom), 4'($urandom));
      end
      send_item(MODE_QUERY, stale_handle, 8'h00, 24'h000000, 12'd0, 12'd0, 4'd0);
      req_tvalid <= 1'b0;

      // Drain: wait for every predicted word, then watch for strays.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d result words, %0d slots freed by sweeps,",
               requests_sent, results_seen, slots_swept);
      $display("a full table, a long output stall and repeated reuse of slot 0");
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
